// File: design/gro_pkg.sv
// Shared types and constants of the rectangle occupancy table.
package gro_pkg;

  localparam int KIND_W     = 3;
  localparam int COORD_IN_W = 8;
  localparam int SIZE_W     = 4;
  localparam int ID_W       = 16;
  // origin plus rectangle offset, signed
  localparam int COORD_W    = COORD_IN_W + 2;
  localparam int MAP_W      = 8;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [MAP_W-1:0] MAP_RESET = 8'd64;

  typedef enum logic [0:0] {
    REG_MAP_WIDTH  = 1'b0,
    REG_MAP_HEIGHT = 1'b1
  } reg_idx_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHECK   = 3'd0,
    KIND_CLAIM   = 3'd1,
    KIND_RELEASE = 3'd2,
    KIND_LOOKUP  = 3'd3,
    KIND_CLEAR   = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CHECK,
    ST_CLAIM,
    ST_RELEASE,
    ST_LOOKUP,
    ST_CLEAR,
    ST_FLUSH,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } walk_t;

endpackage

// File: design/gro_if.sv
// Request and result channel interfaces of the occupancy table.
interface gro_req_if;
  logic                                   valid;
  logic                                   ready;
  logic [gro_pkg::KIND_W-1:0]             kind;
  logic signed [gro_pkg::COORD_IN_W-1:0]  origin_x;
  logic signed [gro_pkg::COORD_IN_W-1:0]  origin_y;
  logic [gro_pkg::SIZE_W-1:0]             rect_w;
  logic [gro_pkg::SIZE_W-1:0]             rect_h;
  logic [gro_pkg::ID_W-1:0]               owner_in;

  modport source (
    output valid, kind, origin_x, origin_y, rect_w, rect_h, owner_in,
    input  ready
  );
  modport sink (
    input  valid, kind, origin_x, origin_y, rect_w, rect_h, owner_in,
    output ready
  );
endinterface

interface gro_rsp_if;
  logic                     valid;
  logic                     ready;
  logic                     is_free;
  logic [gro_pkg::ID_W-1:0] owner_out;

  modport source (
    output valid, is_free, owner_out,
    input  ready
  );
  modport sink (
    input  valid, is_free, owner_out,
    output ready
  );
endinterface

// File: design/gro_ram.sv
// Generic simple dual-port RAM with registered read.
module gro_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: design/gro_cfg.sv
// Map size registers behind the APB-style port.
module gro_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [gro_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [gro_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [gro_pkg::APB_DATA_W-1:0]     prdata,
  output logic                               pready,
  output logic [gro_pkg::MAP_W-1:0]          map_w_o,
  output logic [gro_pkg::MAP_W-1:0]          map_h_o
);

  localparam int MW = gro_pkg::MAP_W;
  localparam int DW = gro_pkg::APB_DATA_W;

  logic [MW-1:0]     map_w_q, map_w_d;
  logic [MW-1:0]     map_h_q, map_h_d;
  logic              wr_en;
  gro_pkg::reg_idx_e reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  // byte offset ignored: word index selects the register
  assign reg_idx = gro_pkg::reg_idx_e'(paddr[2]);

  always_comb begin
    map_w_d = map_w_q;
    map_h_d = map_h_q;
    if (wr_en) begin
      unique case (reg_idx)
        gro_pkg::REG_MAP_WIDTH:  map_w_d = pwdata[MW-1:0];
        gro_pkg::REG_MAP_HEIGHT: map_h_d = pwdata[MW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      gro_pkg::REG_MAP_WIDTH:  prdata = DW'(map_w_q);
      gro_pkg::REG_MAP_HEIGHT: prdata = DW'(map_h_q);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_w_q <= gro_pkg::MAP_RESET;
      map_h_q <= gro_pkg::MAP_RESET;
    end else begin
      map_w_q <= map_w_d;
      map_h_q <= map_h_d;
    end
  end

  assign map_w_o = map_w_q;
  assign map_h_o = map_h_q;

endmodule

// File: design/gro_rect_walk.sv
// Row-major cell walker over a rectangle, one cell per step.
module gro_rect_walk (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic                                  step_i,
  input  logic signed [gro_pkg::COORD_IN_W-1:0] ox_i,
  input  logic signed [gro_pkg::COORD_IN_W-1:0] oy_i,
  input  logic [gro_pkg::SIZE_W-1:0]            w_i,
  input  logic [gro_pkg::SIZE_W-1:0]            h_i,
  output gro_pkg::walk_t                        walk_o
);

  localparam int SW = gro_pkg::SIZE_W;
  localparam int CW = gro_pkg::COORD_W;
  localparam int IW = gro_pkg::COORD_IN_W;

  logic [SW-1:0] dx_q, dx_d;
  logic [SW-1:0] dy_q, dy_d;
  logic          row_end;

  assign row_end = (dx_q == w_i - SW'(1));

  always_comb begin
    dx_d = dx_q;
    dy_d = dy_q;
    if (start_i) begin
      dx_d = '0;
      dy_d = '0;
    end else if (step_i) begin
      if (row_end) begin
        dx_d = '0;
        dy_d = dy_q + SW'(1);
      end else begin
        dx_d = dx_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dx_q <= '0;
      dy_q <= '0;
    end else begin
      dx_q <= dx_d;
      dy_q <= dy_d;
    end
  end

  assign walk_o.x    = {{(CW-IW){ox_i[IW-1]}}, ox_i} + $signed({{(CW-SW){1'b0}}, dx_q});
  assign walk_o.y    = {{(CW-IW){oy_i[IW-1]}}, oy_i} + $signed({{(CW-SW){1'b0}}, dy_q});
  assign walk_o.last = row_end && (dy_q == h_i - SW'(1));

endmodule

// File: design/grid_rect_occupancy_table.sv
// Top level: rectangle occupancy table over a cell-owner RAM.
// Flow: check and claim walk the rectangle (an empty one goes straight to flush), look up
//   reads one cell, release and clear sweep all GRID_DIM*GRID_DIM cells; walk and sweep
//   visit one cell a cycle, then flush and done. One item at a time: the next is taken
//   in the cycle after the output register is loaded; it may still be waiting on the sink.
// Reset: map 64 x 64; a clearing pass over every cell zeroes the RAM before any item.
module grid_rect_occupancy_table #(
  parameter int GRID_DIM   = 128,
  parameter int MAX_RECT   = 8,
  parameter int OWNER_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [gro_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [gro_pkg::APB_DATA_W-1:0] pwdata,
  output logic [gro_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready,
  gro_req_if.sink                        req_i,
  gro_rsp_if.source                      rsp_o
);

  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = gro_pkg::SIZE_W;
  localparam int CW    = gro_pkg::COORD_W;
  localparam int IW    = gro_pkg::COORD_IN_W;
  localparam int IDW   = gro_pkg::ID_W;
  localparam int MW    = gro_pkg::MAP_W;

  gro_pkg::state_e state_q, state_d;

  // request held for the whole operation
  logic signed [IW-1:0]   ox_q, oy_q;
  logic [SW-1:0]          w_q, h_q;
  logic [OWNER_BITS-1:0]  id_q;

  // sweep over all cells for release, clear and the reset pass
  logic [AW-1:0]          sweep_q, sweep_d;
  logic                   sweep_last;
  logic                   sweep_inc;

  // tags of the read that returns next cycle
  logic                   rd_chk_q, rd_chk_d;
  logic                   rd_lkp_q, rd_lkp_d;
  logic                   rd_rel_q, rd_rel_d;
  logic [AW-1:0]          rd_addr_q;

  // result being built, and the output register
  logic                   res_free_q, res_free_d;
  logic [IDW-1:0]         res_own_q, res_own_d;
  logic                   out_valid_q, out_valid_d;
  logic                   out_free_q, out_free_d;
  logic [IDW-1:0]         out_own_q, out_own_d;
  logic                   load_out;

  logic                   accept;
  logic [SW-1:0]          w_cap, h_cap;
  logic                   rect_empty;
  logic [OWNER_BITS+IDW-1:0] id_ext;
  logic [OWNER_BITS+IDW-1:0] rd_ext;

  logic [MW-1:0]          map_w, map_h;

  gro_pkg::walk_t         walk;
  logic signed [CW-1:0]   wx, wy;
  logic                   walk_start, walk_step;
  logic                   in_store, in_map;
  logic [AW-1:0]          walk_addr;

  logic                   ram_we, ram_re;
  logic [AW-1:0]          ram_waddr, ram_raddr;
  logic [OWNER_BITS-1:0]  ram_wdata, ram_rdata;
  logic                   rel_hit;

  gro_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .map_w_o (map_w),
    .map_h_o (map_h)
  );

  gro_rect_walk u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (walk_start),
    .step_i  (walk_step),
    .ox_i    (ox_q),
    .oy_i    (oy_q),
    .w_i     (w_q),
    .h_i     (h_q),
    .walk_o  (walk)
  );

  gro_ram #(
    .WIDTH (OWNER_BITS),
    .DEPTH (CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------------
  assign accept     = req_i.valid && req_i.ready;
  // saturate sizes to the largest rectangle the table supports
  assign w_cap      = (int'(req_i.rect_w) > MAX_RECT) ? SW'(MAX_RECT) : req_i.rect_w;
  assign h_cap      = (int'(req_i.rect_h) > MAX_RECT) ? SW'(MAX_RECT) : req_i.rect_h;
  assign rect_empty = (w_cap == '0) || (h_cap == '0);
  // fit the 16-bit id to the stored owner width, and back
  assign id_ext     = {{OWNER_BITS{1'b0}}, req_i.owner_in};
  assign rd_ext     = {{IDW{1'b0}}, ram_rdata};

  // ---------------------------------------------------------------------------
  // Cell position of the walker: bounds and RAM address
  // ---------------------------------------------------------------------------
  assign wx       = walk.x;
  assign wy       = walk.y;
  assign in_store = !wx[CW-1] && !wy[CW-1] && (int'(wx) < GRID_DIM) && (int'(wy) < GRID_DIM);
  assign in_map   = in_store && (int'(wx) < int'(map_w)) && (int'(wy) < int'(map_h));
  assign walk_addr = AW'($unsigned(wy)) * AW'(GRID_DIM) + AW'($unsigned(wx));

  assign sweep_last = (sweep_q == AW'(CELLS - 1));
  // a release read returns a cell holding the id: write zero back to it
  assign rel_hit    = rd_rel_q && (ram_rdata == id_q);

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gro_pkg::ST_INIT: begin
        if (sweep_last) state_d = gro_pkg::ST_IDLE;
      end
      gro_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (gro_pkg::kind_e'(req_i.kind))
            gro_pkg::KIND_CHECK:
              state_d = rect_empty ? gro_pkg::ST_FLUSH : gro_pkg::ST_CHECK;
            gro_pkg::KIND_CLAIM:
              state_d = rect_empty ? gro_pkg::ST_FLUSH : gro_pkg::ST_CLAIM;
            gro_pkg::KIND_RELEASE: state_d = gro_pkg::ST_RELEASE;
            gro_pkg::KIND_LOOKUP:  state_d = gro_pkg::ST_LOOKUP;
            gro_pkg::KIND_CLEAR:   state_d = gro_pkg::ST_CLEAR;
            default:               state_d = gro_pkg::ST_FLUSH;
          endcase
        end
      end
      gro_pkg::ST_CHECK,
      gro_pkg::ST_CLAIM: begin
        if (walk.last) state_d = gro_pkg::ST_FLUSH;
      end
      gro_pkg::ST_RELEASE,
      gro_pkg::ST_CLEAR: begin
        if (sweep_last) state_d = gro_pkg::ST_FLUSH;
      end
      gro_pkg::ST_LOOKUP: state_d = gro_pkg::ST_FLUSH;
      gro_pkg::ST_FLUSH:  state_d = gro_pkg::ST_DONE;
      gro_pkg::ST_DONE: begin
        if (load_out) state_d = gro_pkg::ST_IDLE;
      end
      default: state_d = gro_pkg::ST_INIT;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control outputs: RAM ports, walker and sweep strobes
  // ---------------------------------------------------------------------------
  always_comb begin
    req_i.ready = 1'b0;
    walk_start  = 1'b0;
    walk_step   = 1'b0;
    sweep_inc   = 1'b0;
    ram_re      = 1'b0;
    ram_raddr   = walk_addr;
    ram_we      = 1'b0;
    ram_waddr   = walk_addr;
    ram_wdata   = id_q;
    rd_chk_d    = 1'b0;
    rd_lkp_d    = 1'b0;
    rd_rel_d    = 1'b0;
    load_out    = 1'b0;
    unique case (state_q)
      gro_pkg::ST_INIT,
      gro_pkg::ST_CLEAR: begin
        sweep_inc = 1'b1;
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        ram_wdata = '0;
      end
      gro_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        walk_start  = 1'b1;
      end
      gro_pkg::ST_CHECK: begin
        // cells outside the map fail without a read
        walk_step = 1'b1;
        ram_re    = in_map;
        rd_chk_d  = in_map;
      end
      gro_pkg::ST_CLAIM: begin
        // drop cells outside the store, write the rest
        walk_step = 1'b1;
        ram_we    = in_store;
      end
      gro_pkg::ST_LOOKUP: begin
        ram_re   = in_store;
        rd_lkp_d = in_store;
      end
      gro_pkg::ST_RELEASE: begin
        sweep_inc = 1'b1;
        ram_re    = 1'b1;
        ram_raddr = sweep_q;
        rd_rel_d  = 1'b1;
      end
      gro_pkg::ST_FLUSH: ;
      gro_pkg::ST_DONE: begin
        load_out = !out_valid_q || rsp_o.ready;
      end
      default: ;
    endcase
    // write-back of a release lands one cell behind the read sweep
    if (rel_hit) begin
      ram_we    = 1'b1;
      ram_waddr = rd_addr_q;
      ram_wdata = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result and output register
  // ---------------------------------------------------------------------------
  always_comb begin
    sweep_d    = sweep_inc ? (sweep_last ? '0 : sweep_q + AW'(1)) : sweep_q;
    res_free_d = res_free_q;
    res_own_d  = res_own_q;
    if (accept) begin
      res_free_d = (gro_pkg::kind_e'(req_i.kind) == gro_pkg::KIND_CHECK);
      res_own_d  = '0;
    end
    if (state_q == gro_pkg::ST_CHECK && !in_map) res_free_d = 1'b0;
    if (rd_chk_q && ram_rdata != '0)            res_free_d = 1'b0;
    if (rd_lkp_q)                               res_own_d  = rd_ext[IDW-1:0];

    out_valid_d = out_valid_q;
    out_free_d  = out_free_q;
    out_own_d   = out_own_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_free_d  = res_free_q;
      out_own_d   = res_own_q;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gro_pkg::ST_INIT;
      sweep_q     <= '0;
      rd_chk_q    <= 1'b0;
      rd_lkp_q    <= 1'b0;
      rd_rel_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      rd_chk_q    <= rd_chk_d;
      rd_lkp_q    <= rd_lkp_d;
      rd_rel_q    <= rd_rel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ox_q <= req_i.origin_x;
      oy_q <= req_i.origin_y;
      w_q  <= w_cap;
      h_q  <= h_cap;
      id_q <= id_ext[OWNER_BITS-1:0];
    end
    rd_addr_q  <= sweep_q;
    res_free_q <= res_free_d;
    res_own_q  <= res_own_d;
    out_free_q <= out_free_d;
    out_own_q  <= out_own_d;
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.is_free   = out_free_q;
  assign rsp_o.owner_out = out_own_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_no_rw_same_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_re && ram_we) |-> (ram_raddr != ram_waddr))
    else $error("read and write of the same cell in one cycle");

  a_one_read_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({rd_chk_q, rd_lkp_q, rd_rel_q}))
    else $error("more than one read tag pending");

  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gro_pkg::ST_INIT) |-> !req_i.ready)
    else $error("item taken during clearing pass");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == gro_pkg::ST_DONE))
    else $error("result posted outside the done state");

  a_walk_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == gro_pkg::ST_CHECK || state_q == gro_pkg::ST_CLAIM) && walk.last)
      |=> (state_q == gro_pkg::ST_FLUSH))
    else $error("rectangle walk did not end on its last cell");

endmodule

// File: sim/tb_grid_rect_occupancy_table.sv
// Self-checking testbench of the rectangle occupancy table: directed table, then random items.
module tb_grid_rect_occupancy_table;

  localparam int CLK_PERIOD     = 20;
  localparam int TIMEOUT_CYCLES = 4_000_000;
  localparam int GRID_DIM       = 128;
  localparam int MAX_RECT       = 8;
  localparam int GRID_CELLS     = GRID_DIM * GRID_DIM;

  // Kinds past the last defined one; the block must treat them as no-ops.
  localparam logic [gro_pkg::KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [gro_pkg::KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam logic [gro_pkg::COORD_IN_W-1:0] COORD_MIN = 8'h80;
  localparam logic [gro_pkg::COORD_IN_W-1:0] COORD_MAX = 8'h7F;
  localparam logic [gro_pkg::COORD_IN_W-1:0] COORD_NEG1 = 8'hFF;

  // Random segments: map size and how hard each side idles.
  localparam int SEGMENTS      = 6;
  localparam int SEG_ITEMS     = 240;
  localparam int SEG_SWEEPS    = 4;
  localparam int SEG_COLS [SEGMENTS] = '{128, 1, 0, 255, 96, 64};
  localparam int SEG_ROWS [SEGMENTS] = '{128, 1, 200, 3, 40, 64};
  localparam int SEG_SEND_IDLE [SEGMENTS] = '{17, 17, 69, 69, 0, 0};
  localparam int SEG_RECV_IDLE [SEGMENTS] = '{69, 69, 17, 17, 0, 0};

  typedef struct packed {
    logic [gro_pkg::KIND_W-1:0]     kind;
    logic [gro_pkg::COORD_IN_W-1:0] origin_x;
    logic [gro_pkg::COORD_IN_W-1:0] origin_y;
    logic [gro_pkg::SIZE_W-1:0]     rect_w;
    logic [gro_pkg::SIZE_W-1:0]     rect_h;
    logic [gro_pkg::ID_W-1:0]       owner_in;
  } request_t;

  typedef struct packed {
    logic                     is_free;
    logic [gro_pkg::ID_W-1:0] owner_out;
  } answer_t;

  // One queued item; has_answer marks rows whose result is written out by hand.
  typedef struct packed {
    request_t req;
    logic     has_answer;
    answer_t  ans;
  } plan_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [gro_pkg::APB_ADDR_W-1:0] paddr;
  logic [gro_pkg::APB_DATA_W-1:0] pwdata;
  logic [gro_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  gro_req_if req_if ();
  gro_rsp_if rsp_if ();

  grid_rect_occupancy_table #(
    .GRID_DIM  (GRID_DIM),
    .MAX_RECT  (MAX_RECT),
    .OWNER_BITS(gro_pkg::ID_W)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #(CLK_PERIOD / 2) clk_i = 1'b1;
    #(CLK_PERIOD / 2) clk_i = 1'b0;
  end

  // Shadow of the cell store and of the map registers.
  logic [gro_pkg::ID_W-1:0] owner_grid [GRID_CELLS];
  int                       map_cols;
  int                       map_rows;

  plan_row_t outgoing_items [$];
  answer_t   pending_answers [$];
  plan_row_t directed_plan [$];
  int        mismatch_count;
  int        send_idle_pct;
  int        recv_idle_pct;

  function automatic bit cell_in_store(int x, int y);
    return x >= 0 && y >= 0 && x < GRID_DIM && y < GRID_DIM;
  endfunction

  // Apply one item to the shadow store and return the answer it must produce.
  function automatic answer_t occupancy_answer(request_t r);
    answer_t a;
    int      ox;
    int      oy;
    int      w;
    int      h;
    int      x;
    int      y;
    a  = '0;
    ox = int'($signed(r.origin_x));
    oy = int'($signed(r.origin_y));
    // Sizes above the largest rectangle saturate.
    w  = (r.rect_w > MAX_RECT) ? MAX_RECT : int'(r.rect_w);
    h  = (r.rect_h > MAX_RECT) ? MAX_RECT : int'(r.rect_h);
    case (r.kind)
      gro_pkg::KIND_CHECK: begin
        // An empty rectangle is free by definition.
        a.is_free = 1'b1;
        for (int dy = 0; dy < h; dy++) begin
          for (int dx = 0; dx < w; dx++) begin
            x = ox + dx;
            y = oy + dy;
            // A cell counts only inside both the store and the configured map.
            if (!cell_in_store(x, y) || x >= map_cols || y >= map_rows) begin
              a.is_free = 1'b0;
            end else if (owner_grid[y * GRID_DIM + x] != '0) begin
              a.is_free = 1'b0;
            end
          end
        end
      end
      gro_pkg::KIND_CLAIM: begin
        // Cells past the store edge are dropped; outside the map but inside the store
        // they are still written. Id zero empties the covered cells.
        for (int dy = 0; dy < h; dy++) begin
          for (int dx = 0; dx < w; dx++) begin
            x = ox + dx;
            y = oy + dy;
            if (cell_in_store(x, y)) begin
              owner_grid[y * GRID_DIM + x] = r.owner_in;
            end
          end
        end
      end
      gro_pkg::KIND_RELEASE: begin
        foreach (owner_grid[i]) begin
          if (owner_grid[i] == r.owner_in) begin
            owner_grid[i] = '0;
          end
        end
      end
      gro_pkg::KIND_LOOKUP: begin
        if (cell_in_store(ox, oy)) begin
          a.owner_out = owner_grid[oy * GRID_DIM + ox];
        end
      end
      gro_pkg::KIND_CLEAR: begin
        foreach (owner_grid[i]) begin
          owner_grid[i] = '0;
        end
      end
      default: begin
      end
    endcase
    return a;
  endfunction

  function automatic plan_row_t plan_row(logic [gro_pkg::KIND_W-1:0] kind,
                                         logic [gro_pkg::COORD_IN_W-1:0] ox,
                                         logic [gro_pkg::COORD_IN_W-1:0] oy,
                                         logic [gro_pkg::SIZE_W-1:0] w,
                                         logic [gro_pkg::SIZE_W-1:0] h,
                                         logic [gro_pkg::ID_W-1:0] id,
                                         logic has_answer, logic is_free,
                                         logic [gro_pkg::ID_W-1:0] owner_out);
    plan_row_t row;
    row.req        = '{kind, ox, oy, w, h, id};
    row.has_answer = has_answer;
    row.ans        = '{is_free, owner_out};
    return row;
  endfunction

  // Append one row to the directed table.
  task automatic add_row(plan_row_t row);
    directed_plan.insert(directed_plan.size(), row);
  endtask

  // Favor a small hot window so claims, checks and look ups keep hitting the same cells;
  // the rest goes to the map edge, the store edge and the whole signed range.
  function automatic logic [gro_pkg::COORD_IN_W-1:0] pick_coord(int span);
    int roll;
    int v;
    roll = $urandom_range(99);
    if (roll < 55) begin
      v = int'($urandom_range(28)) - 4;
    end else if (roll < 75) begin
      v = span - 6 + int'($urandom_range(10));
      if (v > 127) begin
        v = 127 - int'($urandom_range(7));
      end
    end else if (roll < 85) begin
      v = 118 + int'($urandom_range(9));
    end else begin
      v = int'($urandom_range(255));
    end
    return gro_pkg::COORD_IN_W'(v);
  endfunction

  function automatic logic [gro_pkg::SIZE_W-1:0] pick_size();
    if ($urandom_range(99) < 85) begin
      return gro_pkg::SIZE_W'($urandom_range(MAX_RECT));
    end
    return gro_pkg::SIZE_W'($urandom_range(15));
  endfunction

  // A small pool of ids makes releases and look ups meet earlier claims.
  function automatic logic [gro_pkg::ID_W-1:0] pick_owner();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      return '0;
    end else if (roll < 80) begin
      return gro_pkg::ID_W'($urandom_range(6, 1));
    end else if (roll < 85) begin
      return '1;
    end
    return gro_pkg::ID_W'($urandom);
  endfunction

  // Whole-store sweeps visit all GRID_CELLS cells each, so keep them rare and capped.
  function automatic plan_row_t random_row(inout int sweeps_left);
    plan_row_t row;
    int        roll;
    row  = '0;
    roll = $urandom_range(999);
    if (roll < 380) begin
      row.req.kind = gro_pkg::KIND_CHECK;
    end else if (roll < 680) begin
      row.req.kind = gro_pkg::KIND_CLAIM;
    end else if (roll < 930) begin
      row.req.kind = gro_pkg::KIND_LOOKUP;
    end else if (roll < 955) begin
      if (sweeps_left > 0) begin
        row.req.kind = (roll < 945) ? gro_pkg::KIND_RELEASE : gro_pkg::KIND_CLEAR;
        sweeps_left--;
      end else begin
        row.req.kind = gro_pkg::KIND_CHECK;
      end
    end else begin
      row.req.kind = gro_pkg::KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
    end
    row.req.origin_x = pick_coord(map_cols);
    row.req.origin_y = pick_coord(map_rows);
    row.req.rect_w   = pick_size();
    row.req.rect_h   = pick_size();
    row.req.owner_in = pick_owner();
    return row;
  endfunction

  // Hand one item to the driver, keeping at most two queued ahead of the bus.
  task automatic send_item(plan_row_t row);
    while (outgoing_items.size() >= 2) begin
      @(negedge clk_i);
    end
    outgoing_items.insert(outgoing_items.size(), row);
  endtask

  // Hold until every queued item is taken and every result has come back.
  task automatic wait_quiet();
    do begin
      @(negedge clk_i);
    end while (outgoing_items.size() != 0 || pending_answers.size() != 0 || req_if.valid);
  endtask

  // Two-phase APB write; upper data bits carry noise the register must ignore.
  task automatic cfg_write(gro_pkg::reg_idx_e idx, logic [gro_pkg::MAP_W-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gro_pkg::APB_ADDR_W'(idx) << 2;
    pwdata  <= {(gro_pkg::APB_DATA_W - gro_pkg::MAP_W)'($urandom), value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == gro_pkg::REG_MAP_WIDTH) begin
      map_cols = int'(value);
    end else begin
      map_rows = int'(value);
    end
  endtask

  // Request side: predict on every accepted item, hold valid while stalled, otherwise
  // present the next queued item unless the sender idles this cycle.
  always @(posedge clk_i) begin : p_req_drive
    plan_row_t sent_row;
    answer_t   pred;
    if (rst_ni) begin
      if (req_if.valid && req_if.ready) begin
        sent_row = outgoing_items.pop_front();
        pred     = occupancy_answer(sent_row.req);
        pending_answers.insert(pending_answers.size(),
                               sent_row.has_answer ? sent_row.ans : pred);
      end
      if (!(req_if.valid && !req_if.ready)) begin
        if (outgoing_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_if.valid    <= 1'b1;
          req_if.kind     <= outgoing_items[0].req.kind;
          req_if.origin_x <= outgoing_items[0].req.origin_x;
          req_if.origin_y <= outgoing_items[0].req.origin_y;
          req_if.rect_w   <= outgoing_items[0].req.rect_w;
          req_if.rect_h   <= outgoing_items[0].req.rect_h;
          req_if.owner_in <= outgoing_items[0].req.owner_in;
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result side: compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin : p_rsp_check
    answer_t want;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_answers.size() == 0) begin
          $error("result with nothing expected: is_free %0b owner_out %h",
                 rsp_if.is_free, rsp_if.owner_out);
          mismatch_count++;
        end else begin
          want = pending_answers.pop_front();
          if (rsp_if.is_free !== want.is_free) begin
            $error("is_free: expected %0b, got %0b", want.is_free, rsp_if.is_free);
            mismatch_count++;
          end
          if (rsp_if.owner_out !== want.owner_out) begin
            $error("owner_out: expected %h, got %h", want.owner_out, rsp_if.owner_out);
            mismatch_count++;
          end
        end
      end
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int sweeps_left;

    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    req_if.valid    = 1'b0;
    req_if.kind     = '0;
    req_if.origin_x = '0;
    req_if.origin_y = '0;
    req_if.rect_w   = '0;
    req_if.rect_h   = '0;
    req_if.owner_in = '0;
    rsp_if.ready    = 1'b0;
    foreach (owner_grid[i]) begin
      owner_grid[i] = '0;
    end
    map_cols       = int'(gro_pkg::MAP_RESET);
    map_rows       = int'(gro_pkg::MAP_RESET);
    mismatch_count = 0;
    send_idle_pct  = SEG_SEND_IDLE[0];
    recv_idle_pct  = SEG_RECV_IDLE[0];

    // Directed table at the reset map of 64 x 64. The last three columns give the
    // answer where it is plain; the other rows go through the predictor.
    add_row(plan_row(gro_pkg::KIND_LOOKUP, 8'd0, 8'd0, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_CHECK, 8'd0, 8'd0, 4'd8, 4'd8, 16'h0000,
                     1'b1, 1'b1, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_CHECK, COORD_NEG1, 8'd0, 4'd1, 4'd1, 16'h0000,
                     1'b1, 1'b0, 16'h0000));
    // Rectangle touching the last map row and column.
    add_row(plan_row(gro_pkg::KIND_CHECK, 8'd56, 8'd56, 4'd8, 4'd8, 16'h0000,
                     1'b1, 1'b1, 16'h0000));
    // Empty rectangles are free anywhere.
    add_row(plan_row(gro_pkg::KIND_CHECK, 8'd0, 8'd0, 4'd0, 4'd5, 16'h0000,
                     1'b1, 1'b1, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_CHECK, COORD_MIN, COORD_MIN, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b1, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_CHECK, COORD_MAX, COORD_MAX, 4'd15, 4'd15,
                     16'hFFFF, 1'b1, 1'b0, 16'h0000));
    // Oversized claim saturates to 8 x 8.
    add_row(plan_row(gro_pkg::KIND_CLAIM, 8'd0, 8'd0, 4'd15, 4'd9, 16'hFFFF,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_LOOKUP, 8'd7, 8'd7, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'hFFFF));
    add_row(plan_row(gro_pkg::KIND_CHECK, 8'd0, 8'd0, 4'd1, 4'd1, 16'h0000,
                     1'b0, 1'b0, 16'h0000));
    // Claim spilling past the store corner keeps only the cells inside.
    add_row(plan_row(gro_pkg::KIND_CLAIM, 8'd120, 8'd125, 4'd8, 4'd8, 16'h8001,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_LOOKUP, COORD_MAX, COORD_MAX, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'h8001));
    add_row(plan_row(gro_pkg::KIND_LOOKUP, COORD_MIN, 8'd5, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'h0000));
    // Inside the store but outside the map: still written.
    add_row(plan_row(gro_pkg::KIND_CLAIM, 8'd100, 8'd100, 4'd2, 4'd2, 16'h1234,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_LOOKUP, 8'd101, 8'd101, 4'd0, 4'd0, 16'h0000,
                     1'b0, 1'b0, 16'h0000));
    // Claim with id zero empties the covered cells.
    add_row(plan_row(gro_pkg::KIND_CLAIM, 8'd0, 8'd0, 4'd4, 4'd4, 16'h0000,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_LOOKUP, 8'd3, 8'd3, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_LOOKUP, 8'd4, 8'd4, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'hFFFF));
    // Release of id zero must leave the store alone; then a real release.
    add_row(plan_row(gro_pkg::KIND_RELEASE, 8'd0, 8'd0, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_RELEASE, 8'd0, 8'd0, 4'd0, 4'd0, 16'hFFFF,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_LOOKUP, 8'd5, 8'd5, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'h0000));
    // Undefined kinds answer zero and change nothing.
    add_row(plan_row(KIND_SPARE_FIRST, COORD_MAX, COORD_NEG1, 4'd8, 4'd8,
                     16'hAAAA, 1'b1, 1'b0, 16'h0000));
    add_row(plan_row(KIND_SPARE_LAST, COORD_MIN, COORD_MAX, 4'd15, 4'd15,
                     16'h5555, 1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_CLEAR, 8'd0, 8'd0, 4'd0, 4'd0, 16'h0000,
                     1'b1, 1'b0, 16'h0000));
    add_row(plan_row(gro_pkg::KIND_LOOKUP, 8'd101, 8'd101, 4'd0, 4'd0, 16'h0000,
                     1'b0, 1'b0, 16'h0000));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      send_item(directed_plan[i]);
    end
    wait_quiet();

    // Random segments: reprogram the map while idle, then stream items.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      send_idle_pct = SEG_SEND_IDLE[seg];
      recv_idle_pct = SEG_RECV_IDLE[seg];
      cfg_write(gro_pkg::REG_MAP_WIDTH, gro_pkg::MAP_W'(SEG_COLS[seg]));
      cfg_write(gro_pkg::REG_MAP_HEIGHT, gro_pkg::MAP_W'(SEG_ROWS[seg]));
      sweeps_left = SEG_SWEEPS;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        // Now and then drain the block completely before the next item.
        if (n == SEG_ITEMS / 2 || $urandom_range(99) == 0) begin
          wait_quiet();
        end
        send_item(random_row(sweeps_left));
      end
      wait_quiet();
    end

    // Let any stray late result show up before deciding.
    repeat (32) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("grid_rect_occupancy_table regression: pass");
    end else begin
      $display("grid_rect_occupancy_table regression: fail");
    end
    $finish;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("grid_rect_occupancy_table regression: fail");
    $finish;
  end

endmodule
